// File: hdl/wtp_pkg.sv
// ----------------------------------------------------------------------------
// wtp_pkg
// Shared constants, codes and transaction types of the waypoint trajectory
// player: table sizes, request and register codes, payload structs.
// ----------------------------------------------------------------------------
package wtp_pkg;

   // table geometry
   localparam int MAX_WAYPOINTS = 1024;
   localparam int NUM_JOINTS    = 5;
   localparam int ROW_W         = $clog2(MAX_WAYPOINTS);
   localparam int CNT_W         = ROW_W + 1;
   localparam int ENT_DEPTH     = MAX_WAYPOINTS * NUM_JOINTS;
   localparam int ENT_W         = $clog2(ENT_DEPTH);
   localparam int JOINT_W       = 3;
   localparam int DATA_W        = 32;
   localparam int ADV_W         = 20;
   localparam int CSR_IDX_W     = 3;

   // shared multiply-divide unit widths
   localparam int MAG_W  = DATA_W + 1;
   localparam int PROD_W = 2 * DATA_W + 2;

   // microseconds per second, scale of derived rates
   localparam logic [DATA_W-1:0] RATE_SCALE = DATA_W'(1000000);

   // request codes
   localparam logic [1:0] REQ_LOAD     = 2'd0;
   localparam logic [1:0] REQ_FINALIZE = 2'd1;
   localparam logic [1:0] REQ_TICK     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ADVANCE  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOOP     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLD     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_WAIT     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPLICIT = 3'd4;

   localparam logic [JOINT_W-1:0] LAST_JOINT = JOINT_W'(NUM_JOINTS - 1);

   typedef struct packed {
      logic [1:0]               req_type;
      logic [JOINT_W-1:0]       joint_index;
      logic [DATA_W-1:0]        waypoint_time;
      logic signed [DATA_W-1:0] position;
      logic signed [DATA_W-1:0] rate;
      logic                     driver_ready;
   } wtp_req_type;

   typedef struct packed {
      logic [JOINT_W-1:0]       out_joint;
      logic signed [DATA_W-1:0] out_position;
      logic signed [DATA_W-1:0] out_velocity;
      logic signed [DATA_W-1:0] out_accel;
      logic [DATA_W-1:0]        out_time;
      logic                     out_done;
      logic                     out_error;
      logic                     out_last;
   } wtp_rsp_type;

   // request to the shared unit: mag * mul / den, rounded when rnd is set, sign applied after
   typedef struct packed {
      logic              start;
      logic              neg;
      logic              rnd;
      logic [MAG_W-1:0]  mag;
      logic [DATA_W-1:0] mul;
      logic [DATA_W-1:0] den;
   } wtp_div_req_type;

   typedef struct packed {
      logic                     done;
      logic signed [DATA_W-1:0] quot;
      logic [DATA_W-1:0]        rem;
   } wtp_div_rsp_type;

   // flat entry address of one joint of one waypoint
   function automatic logic [ENT_W-1:0] entry_addr(logic [ROW_W-1:0] row,
                                                   logic [JOINT_W-1:0] joint);
      entry_addr = ENT_W'(int'(row) * NUM_JOINTS + int'(joint));
   endfunction

endpackage

// File: hdl/wtp_muldiv.sv
// ----------------------------------------------------------------------------
// wtp_muldiv
// Shared shift-add multiplier and restoring divider. Computes mag * mul / den,
// rounded with ties away from zero when rnd is set and truncated otherwise,
// applies the sign, saturates to signed 32 bits and also returns the remainder.
// ----------------------------------------------------------------------------
module wtp_muldiv
   import wtp_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  wtp_div_req_type div_req,
   output wtp_div_rsp_type div_rsp
);

   localparam int MUL_STEPS = DATA_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int STEP_W    = $clog2(DIV_STEPS);

   typedef enum logic [2:0] {D_IDLE, D_MUL, D_RND, D_DIV, D_FIN} dstate_type;

   dstate_type        state_ff;
   logic [PROD_W-1:0] acc_ff;
   logic [PROD_W-1:0] addend_ff;
   logic [DATA_W-1:0] mul_ff;
   logic [DATA_W-1:0] den_ff;
   logic [MAG_W-1:0]  rem_ff;
   logic              neg_ff;
   logic              rnd_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   logic [DATA_W-1:0] quot_ff;
   logic [DATA_W-1:0] remout_ff;

   logic [MAG_W-1:0]  rem_sh;
   logic              rem_ge;
   logic [MAG_W-1:0]  rem_in;
   logic [PROD_W-1:0] acc_in;
   logic [DATA_W-1:0] sat_q;

   // one restoring division step
   always_comb begin
      rem_sh = {rem_ff[DATA_W-1:0], acc_ff[PROD_W-1]};
      rem_ge = (rem_sh >= {1'b0, den_ff});
      rem_in = rem_ge ? (rem_sh - {1'b0, den_ff}) : rem_sh;
      acc_in = {acc_ff[PROD_W-2:0], rem_ge};
   end

   // sign and saturation of the quotient
   always_comb begin
      if (!neg_ff) begin
         if (acc_ff > PROD_W'(32'h7FFF_FFFF)) begin
            sat_q = 32'h7FFF_FFFF;
         end else begin
            sat_q = acc_ff[DATA_W-1:0];
         end
      end else begin
         if (acc_ff > PROD_W'(32'h8000_0000)) begin
            sat_q = 32'h8000_0000;
         end else begin
            sat_q = (~acc_ff[DATA_W-1:0]) + 1'b1;
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (div_req.start) begin
                  acc_ff    <= '0;
                  addend_ff <= PROD_W'(div_req.mag);
                  mul_ff    <= div_req.mul;
                  den_ff    <= div_req.den;
                  neg_ff    <= div_req.neg;
                  rnd_ff    <= div_req.rnd;
                  step_ff   <= '0;
                  state_ff  <= D_MUL;
               end
            end
            D_MUL: begin
               if (mul_ff[0]) begin
                  acc_ff <= acc_ff + addend_ff;
               end
               addend_ff <= {addend_ff[PROD_W-2:0], 1'b0};
               mul_ff    <= {1'b0, mul_ff[DATA_W-1:1]};
               step_ff   <= step_ff + 1'b1;
               if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
                  state_ff <= D_RND;
               end
            end
            D_RND: begin
               if (rnd_ff) begin
                  acc_ff <= acc_ff + PROD_W'(den_ff[DATA_W-1:1]);
               end
               rem_ff   <= '0;
               step_ff  <= '0;
               state_ff <= D_DIV;
            end
            D_DIV: begin
               rem_ff  <= rem_in;
               acc_ff  <= acc_in;
               step_ff <= step_ff + 1'b1;
               if (step_ff == STEP_W'(DIV_STEPS - 1)) begin
                  state_ff <= D_FIN;
               end
            end
            D_FIN: begin
               quot_ff   <= sat_q;
               remout_ff <= rem_ff[DATA_W-1:0];
               done_ff   <= 1'b1;
               state_ff  <= D_IDLE;
            end
            default: state_ff <= D_IDLE;
         endcase
      end
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quot = quot_ff;
   assign div_rsp.rem  = remout_ff;

endmodule

// File: hdl/waypoint_trajectory_player_core.sv
// ----------------------------------------------------------------------------
// waypoint_trajectory_player_core
// Waypoint table with linear interpolation playback.
// A load stores one joint of a waypoint; a finalize runs the derivation passes
// over every span and joint; a tick passes waypoints or wraps and interpolates
// each joint (a held or short span joint is copied), using the shared shift-add
// multiply-divide unit for the arithmetic. One transaction at a time; busy is
// high until it finishes, for a tick that emits results as its last result is
// issued. Results are strobed on rsp_valid and cannot be stalled. Synchronous
// reset empties the table, stops playback and loads the register defaults.
// ----------------------------------------------------------------------------
module waypoint_trajectory_player_core
   import wtp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  wtp_req_type          req_data,
   output logic                 rsp_valid,
   output wtp_rsp_type          rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADV_W-1:0]     csr_wdata
);

   localparam logic [1:0] FLD_POS = 2'd0;
   localparam logic [1:0] FLD_VEL = 2'd1;
   localparam logic [1:0] FLD_ACC = 2'd2;

   typedef enum logic [4:0] {
      S_IDLE, S_LOAD, S_TICK, S_WRAP, S_SEEK, S_SEEK_CMP, S_SPAN0, S_SPAN1, S_SPAN2,
      S_JL, S_JR, S_JC, S_JCALC, S_JWAIT, S_EMIT,
      S_FIN, S_FROW, S_FT1, S_FT2, S_FJL, S_FJR, S_FJC, S_FCALC, S_FWAIT, S_FWR,
      S_FCOPY, S_FCOPYW, S_FZERO
   } state_type;

   // configuration registers
   logic [ADV_W-1:0] adv_ff;
   logic             loop_ff;
   logic             hold_ff;
   logic             wait_ff;
   logic             expl_ff;

   // control and playback state
   state_type         state_ff;
   wtp_req_type       req_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [ROW_W-1:0]  cursor_ff;
   logic [DATA_W-1:0] play_ff;
   logic              started_ff;
   logic              completed_ff;
   logic              err_ff;
   logic [DATA_W-1:0] last_time_ff;

   // working registers
   logic [DATA_W-1:0]        t_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [JOINT_W-1:0]       joint_ff;
   logic [1:0]               field_ff;
   logic                     pass_ff;
   logic                     direct_ff;
   logic                     done_ff;
   logic [DATA_W-1:0]        time_a_ff;
   logic [DATA_W-1:0]        span_ff;
   logic [DATA_W-1:0]        num_ff;
   logic signed [DATA_W-1:0] fin_val_ff;
   logic signed [DATA_W-1:0] lhs_ff [3];
   logic signed [DATA_W-1:0] rhs_ff [3];
   logic signed [DATA_W-1:0] res_ff [3];

   // result register
   logic        rsp_valid_ff;
   wtp_rsp_type rsp_ff;

   // memories
   logic [DATA_W-1:0]        time_mem [MAX_WAYPOINTS];
   logic signed [DATA_W-1:0] pos_mem  [ENT_DEPTH];
   logic signed [DATA_W-1:0] rate_mem [ENT_DEPTH];
   logic signed [DATA_W-1:0] acc_mem  [ENT_DEPTH];
   logic [DATA_W-1:0]        time_rd_ff;
   logic signed [DATA_W-1:0] pos_rd_ff;
   logic signed [DATA_W-1:0] rate_rd_ff;
   logic signed [DATA_W-1:0] acc_rd_ff;

   logic [ROW_W-1:0]         time_raddr;
   logic [ROW_W-1:0]         time_waddr;
   logic                     time_we;
   logic [ENT_W-1:0]         ent_raddr;
   logic [ENT_W-1:0]         ent_waddr;
   logic                     pos_we;
   logic                     rate_we;
   logic                     acc_we;
   logic signed [DATA_W-1:0] ent_wdata;

   // shared unit
   wtp_div_req_type div_req;
   wtp_div_rsp_type div_rsp;

   // helpers
   logic [ROW_W-1:0]         row_next;
   logic [ROW_W-1:0]         cur_next;
   logic [ROW_W-1:0]         cnt_m1;
   logic [ROW_W-1:0]         cnt_m2;
   logic                     joint_ok;
   logic                     load_ok;
   logic [DATA_W:0]          adv_sum;
   logic [DATA_W-1:0]        t_new;
   logic                     past_end;
   logic [DATA_W-1:0]        span_c;
   logic [DATA_W-1:0]        num_c;
   logic signed [DATA_W:0]   diff;
   logic [1:0]               src_fld;
   logic signed [DATA_W-1:0] dst_rd;

   assign row_next = row_ff + 1'b1;
   assign cur_next = cursor_ff + 1'b1;
   assign cnt_m1   = ROW_W'(count_ff - 1'b1);
   assign cnt_m2   = ROW_W'(count_ff - 2'd2);

   // load checks
   always_comb begin
      joint_ok = (int'(req_ff.joint_index) < NUM_JOINTS);
      load_ok  = joint_ok && (count_ff != CNT_W'(MAX_WAYPOINTS)) &&
                 !((count_ff != '0) && (req_ff.waypoint_time < last_time_ff));
   end

   // tick time update and end check
   always_comb begin
      adv_sum  = {1'b0, play_ff} + (DATA_W+1)'(adv_ff);
      if (!started_ff) begin
         t_new = '0;
      end else if (adv_sum[DATA_W]) begin
         t_new = '1;
      end else begin
         t_new = adv_sum[DATA_W-1:0];
      end
      past_end = (last_time_ff != '0) && (t_new > last_time_ff);
   end

   // span and clamped offset of the current segment
   always_comb begin
      span_c = time_rd_ff - time_a_ff;
      num_c  = (t_ff < time_a_ff) ? '0 : (t_ff - time_a_ff);
      if (num_c > span_c) begin
         num_c = span_c;
      end
   end

   // difference fed to the shared unit
   always_comb begin
      src_fld = pass_ff ? FLD_VEL : FLD_POS;
      if (state_ff == S_FCALC) begin
         diff = (DATA_W+1)'(rhs_ff[src_fld]) - (DATA_W+1)'(lhs_ff[src_fld]);
      end else begin
         diff = (DATA_W+1)'(rhs_ff[field_ff]) - (DATA_W+1)'(lhs_ff[field_ff]);
      end
      dst_rd = pass_ff ? acc_rd_ff : rate_rd_ff;
   end

   // shared unit request
   always_comb begin
      div_req.start = 1'b0;
      div_req.neg   = diff[DATA_W];
      div_req.rnd   = 1'b1;
      div_req.mag   = diff[DATA_W] ? MAG_W'(-diff) : MAG_W'(diff);
      div_req.mul   = num_ff;
      div_req.den   = span_ff;
      case (state_ff)
         S_JCALC: begin
            div_req.start = 1'b1;
         end
         S_FCALC: begin
            div_req.start = 1'b1;
            div_req.mul   = RATE_SCALE;
         end
         S_TICK: begin
            div_req.start = !(wait_ff && !req_ff.driver_ready) && (count_ff != '0) &&
                            !(completed_ff && !loop_ff) && past_end && loop_ff;
            div_req.neg   = 1'b0;
            div_req.rnd   = 1'b0;
            div_req.mag   = MAG_W'(t_new - 1'b1);
            div_req.mul   = DATA_W'(1);
            div_req.den   = last_time_ff;
         end
         default: ;
      endcase
   end

   // memory addresses and write strobes
   always_comb begin
      time_raddr = row_ff;
      ent_raddr  = entry_addr(row_ff, joint_ff);
      time_waddr = count_ff[ROW_W-1:0];
      time_we    = 1'b0;
      ent_waddr  = entry_addr(row_ff, joint_ff);
      ent_wdata  = fin_val_ff;
      pos_we     = 1'b0;
      rate_we    = 1'b0;
      acc_we     = 1'b0;
      case (state_ff)
         S_SEEK:  time_raddr = cur_next;
         S_SPAN0: time_raddr = cursor_ff;
         S_SPAN1: time_raddr = cur_next;
         S_FT1:   time_raddr = row_next;
         S_JR, S_FJR: ent_raddr = entry_addr(row_next, joint_ff);
         S_FCOPY: ent_raddr = entry_addr(cnt_m2, joint_ff);
         S_LOAD: begin
            ent_waddr = entry_addr(count_ff[ROW_W-1:0], req_ff.joint_index);
            if (load_ok) begin
               pos_we  = 1'b1;
               rate_we = 1'b1;
               acc_we  = 1'b1;
               time_we = (req_ff.joint_index == LAST_JOINT);
            end
         end
         S_FWR: begin
            rate_we = !pass_ff;
            acc_we  = pass_ff;
         end
         S_FCOPYW: begin
            ent_waddr = entry_addr(cnt_m1, joint_ff);
            ent_wdata = dst_rd;
            rate_we   = !pass_ff;
            acc_we    = pass_ff;
         end
         S_FZERO: begin
            ent_waddr = entry_addr('0, joint_ff);
            ent_wdata = '0;
            rate_we   = !pass_ff;
            acc_we    = pass_ff;
         end
         default: ;
      endcase
   end

   // waypoint memories, read data registered
   always_ff @(posedge clock) begin
      if (time_we) begin
         time_mem[time_waddr] <= req_ff.waypoint_time;
      end
      time_rd_ff <= time_mem[time_raddr];
   end

   always_ff @(posedge clock) begin
      if (pos_we) begin
         pos_mem[ent_waddr] <= req_ff.position;
      end
      pos_rd_ff <= pos_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (rate_we) begin
         rate_mem[ent_waddr] <= (state_ff == S_LOAD) ? req_ff.rate : ent_wdata;
      end
      rate_rd_ff <= rate_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (acc_we) begin
         acc_mem[ent_waddr] <= (state_ff == S_LOAD) ? '0 : ent_wdata;
      end
      acc_rd_ff <= acc_mem[ent_raddr];
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         adv_ff  <= ADV_W'(10000);
         loop_ff <= 1'b0;
         hold_ff <= 1'b1;
         wait_ff <= 1'b1;
         expl_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ADVANCE:  adv_ff  <= csr_wdata;
            CSR_LOOP:     loop_ff <= csr_wdata[0];
            CSR_HOLD:     hold_ff <= csr_wdata[0];
            CSR_WAIT:     wait_ff <= csr_wdata[0];
            CSR_EXPLICIT: expl_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // main sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         play_ff      <= '0;
         started_ff   <= 1'b0;
         completed_ff <= 1'b0;
         err_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (start) begin
                  req_ff <= req_data;
                  case (req_data.req_type)
                     REQ_LOAD:     state_ff <= S_LOAD;
                     REQ_FINALIZE: state_ff <= S_FIN;
                     REQ_TICK:     state_ff <= S_TICK;
                     default:      state_ff <= S_IDLE;
                  endcase
               end
            end

            // single joint load
            S_LOAD: begin
               if (joint_ok && !load_ok) begin
                  err_ff <= 1'b1;
               end
               if (load_ok && (req_ff.joint_index == LAST_JOINT)) begin
                  last_time_ff <= req_ff.waypoint_time;
                  count_ff     <= count_ff + 1'b1;
               end
               state_ff <= S_IDLE;
            end

            // tick: advance, wrap or complete
            S_TICK: begin
               joint_ff  <= '0;
               direct_ff <= 1'b1;
               done_ff   <= 1'b1;
               row_ff    <= cnt_m1;
               if ((wait_ff && !req_ff.driver_ready) || (count_ff == '0)) begin
                  state_ff <= S_IDLE;
               end else if (completed_ff && !loop_ff) begin
                  t_ff     <= play_ff;
                  state_ff <= hold_ff ? S_JL : S_IDLE;
               end else begin
                  started_ff <= 1'b1;
                  if (!started_ff) begin
                     cursor_ff    <= '0;
                     completed_ff <= 1'b0;
                  end
                  play_ff <= t_new;
                  t_ff    <= t_new;
                  if (past_end && loop_ff) begin
                     state_ff <= S_WRAP;
                  end else if (past_end) begin
                     completed_ff <= 1'b1;
                     state_ff     <= hold_ff ? S_JL : S_IDLE;
                  end else begin
                     state_ff <= S_SEEK;
                  end
               end
            end
            S_WRAP: begin
               if (div_rsp.done) begin
                  play_ff   <= div_rsp.rem + 1'b1;
                  t_ff      <= div_rsp.rem + 1'b1;
                  cursor_ff <= '0;
                  state_ff  <= S_SEEK;
               end
            end

            // move the cursor forward past waypoints before the time
            S_SEEK: begin
               if (({1'b0, cursor_ff} + 1'b1) < count_ff) begin
                  state_ff <= S_SEEK_CMP;
               end else begin
                  state_ff <= S_SPAN0;
               end
            end
            S_SEEK_CMP: begin
               if (time_rd_ff < t_ff) begin
                  cursor_ff <= cur_next;
                  state_ff  <= S_SEEK;
               end else begin
                  state_ff <= S_SPAN0;
               end
            end

            // segment span and offset
            S_SPAN0: begin
               row_ff   <= cursor_ff;
               joint_ff <= '0;
               done_ff  <= 1'b0;
               if (({1'b0, cursor_ff} + 1'b1) >= count_ff) begin
                  direct_ff <= 1'b1;
                  state_ff  <= S_JL;
               end else begin
                  state_ff <= S_SPAN1;
               end
            end
            S_SPAN1: begin
               time_a_ff <= time_rd_ff;
               state_ff  <= S_SPAN2;
            end
            S_SPAN2: begin
               span_ff   <= span_c;
               num_ff    <= num_c;
               direct_ff <= (span_c <= DATA_W'(1));
               state_ff  <= S_JL;
            end

            // per joint interpolation
            S_JL: state_ff <= S_JR;
            S_JR: begin
               lhs_ff[FLD_POS] <= pos_rd_ff;
               lhs_ff[FLD_VEL] <= rate_rd_ff;
               lhs_ff[FLD_ACC] <= acc_rd_ff;
               state_ff        <= S_JC;
            end
            S_JC: begin
               rhs_ff[FLD_POS] <= pos_rd_ff;
               rhs_ff[FLD_VEL] <= rate_rd_ff;
               rhs_ff[FLD_ACC] <= acc_rd_ff;
               field_ff        <= FLD_POS;
               if (direct_ff) begin
                  res_ff[FLD_POS] <= lhs_ff[FLD_POS];
                  res_ff[FLD_VEL] <= lhs_ff[FLD_VEL];
                  res_ff[FLD_ACC] <= lhs_ff[FLD_ACC];
                  state_ff        <= S_EMIT;
               end else begin
                  state_ff <= S_JCALC;
               end
            end
            S_JCALC: state_ff <= S_JWAIT;
            S_JWAIT: begin
               if (div_rsp.done) begin
                  res_ff[field_ff] <= lhs_ff[field_ff] + div_rsp.quot;
                  if (field_ff == FLD_ACC) begin
                     state_ff <= S_EMIT;
                  end else begin
                     field_ff <= field_ff + 1'b1;
                     state_ff <= S_JCALC;
                  end
               end
            end
            S_EMIT: begin
               rsp_valid_ff        <= 1'b1;
               rsp_ff.out_joint    <= joint_ff;
               rsp_ff.out_position <= res_ff[FLD_POS];
               rsp_ff.out_velocity <= res_ff[FLD_VEL];
               rsp_ff.out_accel    <= res_ff[FLD_ACC];
               rsp_ff.out_time     <= t_ff;
               rsp_ff.out_done     <= done_ff;
               rsp_ff.out_error    <= err_ff;
               rsp_ff.out_last     <= (joint_ff == LAST_JOINT);
               if (joint_ff == LAST_JOINT) begin
                  state_ff <= S_IDLE;
               end else begin
                  joint_ff <= joint_ff + 1'b1;
                  state_ff <= S_JL;
               end
            end

            // finalize: restart playback and run the derivation passes
            S_FIN: begin
               cursor_ff    <= '0;
               play_ff      <= '0;
               started_ff   <= 1'b0;
               completed_ff <= 1'b0;
               pass_ff      <= expl_ff;
               row_ff       <= '0;
               joint_ff     <= '0;
               if (count_ff >= CNT_W'(2)) begin
                  state_ff <= S_FROW;
               end else if (count_ff == CNT_W'(1)) begin
                  state_ff <= S_FZERO;
               end else begin
                  state_ff <= S_IDLE;
               end
            end
            S_FROW: state_ff <= S_FT1;
            S_FT1: begin
               time_a_ff <= time_rd_ff;
               state_ff  <= S_FT2;
            end
            S_FT2: begin
               span_ff  <= span_c;
               joint_ff <= '0;
               state_ff <= S_FJL;
            end
            S_FJL: state_ff <= S_FJR;
            S_FJR: begin
               lhs_ff[FLD_POS] <= pos_rd_ff;
               lhs_ff[FLD_VEL] <= rate_rd_ff;
               lhs_ff[FLD_ACC] <= acc_rd_ff;
               state_ff        <= S_FJC;
            end
            S_FJC: begin
               rhs_ff[FLD_POS] <= pos_rd_ff;
               rhs_ff[FLD_VEL] <= rate_rd_ff;
               rhs_ff[FLD_ACC] <= acc_rd_ff;
               if (span_ff <= DATA_W'(1)) begin
                  fin_val_ff <= '0;
                  state_ff   <= S_FWR;
               end else begin
                  state_ff <= S_FCALC;
               end
            end
            S_FCALC: state_ff <= S_FWAIT;
            S_FWAIT: begin
               if (div_rsp.done) begin
                  fin_val_ff <= div_rsp.quot;
                  state_ff   <= S_FWR;
               end
            end
            S_FWR: begin
               if (joint_ff == LAST_JOINT) begin
                  joint_ff <= '0;
                  if (({1'b0, row_ff} + 2'd2) == count_ff) begin
                     state_ff <= S_FCOPY;
                  end else begin
                     row_ff   <= row_next;
                     state_ff <= S_FROW;
                  end
               end else begin
                  joint_ff <= joint_ff + 1'b1;
                  state_ff <= S_FJL;
               end
            end

            // last waypoint copies the one before it, or a lone one gets zero
            S_FCOPY: state_ff <= S_FCOPYW;
            S_FCOPYW, S_FZERO: begin
               if (joint_ff == LAST_JOINT) begin
                  joint_ff <= '0;
                  row_ff   <= '0;
                  if (!pass_ff) begin
                     pass_ff  <= 1'b1;
                     state_ff <= (count_ff >= CNT_W'(2)) ? S_FROW : S_FZERO;
                  end else begin
                     state_ff <= S_IDLE;
                  end
               end else begin
                  joint_ff <= joint_ff + 1'b1;
                  state_ff <= (state_ff == S_FZERO) ? S_FZERO : S_FCOPY;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   wtp_muldiv u_muldiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
